@@ rtl/core/ple_pkg.sv @@
// ple_pkg: shared constants and types for the positional list engine.
// Op codes, status codes, cell command codes and the cell command struct.
// No dependencies.
`default_nettype none

package ple_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int MAX_RUN      = 16;
    // widest count/index field the cell row ever needs (CAPACITY up to 256)
    localparam int CNT_W_MAX    = 9;

    // op codes
    localparam logic [3:0] OP_INS_HEAD = 4'd0;
    localparam logic [3:0] OP_INS_TAIL = 4'd1;
    localparam logic [3:0] OP_INS_AT   = 4'd2;
    localparam logic [3:0] OP_DEL_HEAD = 4'd3;
    localparam logic [3:0] OP_DEL_TAIL = 4'd4;
    localparam logic [3:0] OP_DEL_AT   = 4'd5;
    localparam logic [3:0] OP_REPLACE  = 4'd6;
    localparam logic [3:0] OP_DUMP_FWD = 4'd7;
    localparam logic [3:0] OP_DUMP_REV = 4'd8;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // cell commands
    localparam logic [2:0] CM_HOLD = 3'd0;
    localparam logic [2:0] CM_INS  = 3'd1;
    localparam logic [2:0] CM_DEL  = 3'd2;
    localparam logic [2:0] CM_WR   = 3'd3;
    localparam logic [2:0] CM_ROTL = 3'd4;
    localparam logic [2:0] CM_ROTR = 3'd5;

    typedef struct packed {
        logic [2:0]           mode;
        logic [CNT_W_MAX-1:0] pos;  // 0-based target index
        logic [CNT_W_MAX-1:0] cnt;  // occupancy before the operation
    } t_cell_cmd;

endpackage

`default_nettype wire

@@ rtl/core/ple_cell.sv @@
// ple_cell: one storage cell of the list row.
// Holds one entry and picks its next value from itself, its neighbors,
// the wrap bus or the input value. Depends on ple_pkg.
`default_nettype none

module ple_cell
    import ple_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire                 i_clk,
    input  wire  t_cell_cmd     i_cmd,
    input  wire  signed [31:0]  i_left,
    input  wire  signed [31:0]  i_right,
    input  wire  signed [31:0]  i_wrap,
    input  wire  signed [31:0]  i_value,
    output logic signed [31:0]  o_data
);

    localparam logic [CNT_W_MAX-1:0] IDX_V = CNT_W_MAX'(IDX);
    localparam logic [CNT_W_MAX-1:0] IDX_N = CNT_W_MAX'(IDX + 1);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_cmd.mode)
            CM_INS: begin
                if (IDX_V == i_cmd.pos) begin
                    n_data = i_value;
                end else if (IDX_V > i_cmd.pos && IDX_V <= i_cmd.cnt) begin
                    n_data = i_left;
                end
            end
            CM_DEL: begin
                if (IDX_V >= i_cmd.pos && IDX_N < i_cmd.cnt) begin
                    n_data = i_right;
                end
            end
            CM_WR: begin
                if (IDX_V == i_cmd.pos) begin
                    n_data = i_value;
                end
            end
            CM_ROTL: begin
                if (IDX_N < i_cmd.cnt) begin
                    n_data = i_right;
                end else if (IDX_N == i_cmd.cnt) begin
                    n_data = i_wrap;
                end
            end
            CM_ROTR: begin
                if (IDX_V == '0) begin
                    n_data = i_wrap;
                end else if (IDX_V < i_cmd.cnt) begin
                    n_data = i_left;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

@@ rtl/core/positional_list_engine.sv @@
// positional_list_engine: top level of the bounded positional list.
// Instantiates a row of ple_cell, one per entry. Depends on ple_pkg, ple_cell.
`default_nettype none
//
// Usage
//   Command channel: an item (i_op, i_position, i_value) is taken at a rising
//   edge with start high and busy low.
//   Result channel: each result shows on o_status, o_entry_value,
//   o_entry_count and o_last for one cycle with o_valid high. The receiver
//   cannot stall; every result is taken in its cycle.
//   Inserts, deletes, replace and error cases finish in the accept cycle:
//   every neighbor cell shifts one place at once. The single result appears
//   in the cycle after acceptance and busy stays low, so one such item can be
//   given every cycle.
//   Dumps rotate the occupied cells one place per cycle through the row,
//   reading the head cell (forward) or the tail cell (reverse). A dump of n
//   entries holds busy while they rotate, giving registered results for the
//   first min(n, MAX_RUN) of them; the remaining rotations restore the
//   order. An empty dump answers like any other item.
//   Reset (i_rst_n low, synchronous) clears the count and the control state;
//   cell contents are not cleared and are only read below the count.

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire         [3:0]  i_op,
    input  wire         [7:0]  i_position,
    input  wire  signed [31:0] i_value,
    output logic               o_valid,
    output logic        [1:0]  o_status,
    output logic signed [31:0] o_entry_value,
    output logic        [4:0]  o_entry_count,
    output logic               o_last
);

    localparam int CW = $clog2(CAPACITY + 1);              // count width
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = ((CW > 8) ? CW : 8) + 1;           // position compares
    localparam int XW = (CW > 5) ? CW : 5;                 // run compares

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic              r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_k, n_k;
    logic              r_dir, n_dir;          // 1: reverse dump

    logic              r_valid, n_valid;
    logic [1:0]        r_status, n_status;
    logic signed [31:0] r_value, n_value;
    logic [4:0]        r_ocount;
    logic              r_last, n_last;

    t_cell_cmd          w_cmd;
    logic signed [31:0] w_cells [CAPACITY];
    logic signed [31:0] w_dump_data;
    logic [CW-1:0]      w_tail_cw;
    logic [IW-1:0]      w_tail;
    logic               w_accept;
    logic               w_full, w_empty;
    logic [PW-1:0]      w_pos_x, w_cnt_x;
    logic [XW-1:0]      w_k_x, w_cnt_e, w_run, w_ncnt_e;
    logic [CNT_W_MAX-1:0] w_pos0;

    assign busy     = (r_state == S_DUMP);
    assign w_accept = start && !busy;
    assign w_full   = (r_count >= CW'(CAPACITY));
    assign w_empty  = (r_count == '0);
    assign w_pos_x  = PW'(i_position);
    assign w_cnt_x  = PW'(r_count);
    assign w_pos0   = CNT_W_MAX'(i_position) - CNT_W_MAX'(1);

    // tail cell drives the reverse dump and the right-rotate wrap
    assign w_tail_cw   = r_count - CW'(1);
    assign w_tail      = w_tail_cw[IW-1:0];
    assign w_dump_data = r_dir ? w_cells[w_tail] : w_cells[0];

    // dump run bookkeeping
    assign w_k_x   = XW'(r_k);
    assign w_cnt_e = XW'(r_count);
    assign w_run   = (w_cnt_e < XW'(MAX_RUN)) ? w_cnt_e : XW'(MAX_RUN);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_k        = r_k;
        n_dir      = r_dir;
        n_valid    = 1'b0;
        n_status   = ST_OK;
        n_value    = '0;
        n_last     = 1'b1;
        w_cmd.mode = CM_HOLD;
        w_cmd.pos  = '0;
        w_cmd.cnt  = CNT_W_MAX'(r_count);

        if (r_state == S_DUMP) begin
            w_cmd.mode = r_dir ? CM_ROTR : CM_ROTL;
            if (w_k_x < w_run) begin
                n_valid = 1'b1;
                n_value = w_dump_data;
                n_last  = (w_k_x + XW'(1) == w_run);
            end
            n_k = r_k + CW'(1);
            if (w_k_x + XW'(1) == w_cnt_e) begin
                n_state = S_IDLE;
            end
        end else if (w_accept) begin
            n_valid = 1'b1;
            case (i_op)
                OP_INS_HEAD, OP_INS_TAIL: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_cmd.mode = CM_INS;
                        w_cmd.pos  = (i_op == OP_INS_HEAD) ? '0 : CNT_W_MAX'(r_count);
                        n_count    = r_count + CW'(1);
                    end
                end
                OP_INS_AT: begin
                    if (w_pos_x == '0 || w_pos_x > w_cnt_x + PW'(1)) begin
                        n_status = ST_RANGE;
                    end else if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_cmd.mode = CM_INS;
                        w_cmd.pos  = w_pos0;
                        n_count    = r_count + CW'(1);
                    end
                end
                OP_DEL_HEAD, OP_DEL_TAIL: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_cmd.mode = CM_DEL;
                        w_cmd.pos  = (i_op == OP_DEL_HEAD) ? '0 : CNT_W_MAX'(w_tail_cw);
                        n_count    = r_count - CW'(1);
                    end
                end
                OP_DEL_AT: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else if (w_pos_x == '0 || w_pos_x > w_cnt_x) begin
                        n_status = ST_RANGE;
                    end else begin
                        w_cmd.mode = CM_DEL;
                        w_cmd.pos  = w_pos0;
                        n_count    = r_count - CW'(1);
                    end
                end
                OP_REPLACE: begin
                    if (w_pos_x == '0 || w_pos_x > w_cnt_x) begin
                        n_status = ST_RANGE;
                    end else begin
                        w_cmd.mode = CM_WR;
                        w_cmd.pos  = w_pos0;
                    end
                end
                OP_DUMP_FWD, OP_DUMP_REV: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        // results come from the dump cycles instead
                        n_valid = 1'b0;
                        n_state = S_DUMP;
                        n_k     = '0;
                        n_dir   = (i_op == OP_DUMP_REV);
                    end
                end
                default: begin
                    n_status = ST_RANGE;
                end
            endcase
        end
    end

    assign w_ncnt_e = XW'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_k     <= '0;
            r_dir   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_k     <= n_k;
            r_dir   <= n_dir;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_value  <= n_value;
        r_ocount <= w_ncnt_e[4:0];
        r_last   <= n_last;
    end

    // cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam int GL = (g > 0) ? g - 1 : 0;
        localparam int GR = (g < CAPACITY - 1) ? g + 1 : CAPACITY - 1;
        ple_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_left  (w_cells[GL]),
            .i_right (w_cells[GR]),
            .i_wrap  (w_dump_data),
            .i_value (i_value),
            .o_data  (w_cells[g])
        );
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_entry_value = r_value;
    assign o_entry_count = r_ocount;
    assign o_last        = r_last;

    // count never exceeds the store
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("count above capacity");

    // a non-empty dump raises busy
    a_dump_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_op == OP_DUMP_FWD || i_op == OP_DUMP_REV) && !w_empty)
        |=> busy)
        else $error("dump did not enter run");

    // error results are single-result runs
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> o_last)
        else $error("error result not last");

    // error results carry a zero value; only dumped entries carry a value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_entry_value == '0))
        else $error("error result with value");

    // count does not move during a dump
    a_dump_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> $stable(r_count))
        else $error("count changed during dump");

endmodule

`default_nettype wire

@@ tb/tb_positional_list_engine.sv @@
// Self-checking testbench for positional_list_engine: a scoreboard class predicts every
// result of the list (inserts, deletes, replace, dumps) and checks the result stream.
// Depends on ple_pkg and positional_list_engine.
`timescale 1ns / 1ps

import ple_pkg::*;

class list_scoreboard;
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
        logic [4:0]  count;
        logic        is_last;
    } list_result_t;

    localparam int DEPTH     = CAPACITY_DEF;
    localparam int PRINT_CAP = 40;

    logic [31:0]  cells [DEPTH];
    int unsigned  occupancy = 0;
    list_result_t awaited_q [$];
    int           errors = 0;
    int           items = 0;
    int           results = 0;
    int           dumps = 0;
    int           status_seen [4] = '{0, 0, 0, 0};

    function int pending();
        return awaited_q.size();
    endfunction

    function void push_result(logic [1:0] st, logic [31:0] val, logic is_last);
        list_result_t r;
        r.status  = st;
        r.value   = val;
        r.count   = occupancy[4:0];
        r.is_last = is_last;
        awaited_q.push_back(r);
        status_seen[st]++;
    endfunction

    // open a hole at 1-based slot p, everything from p on moves toward the tail
    function void shift_in(int unsigned p, logic [31:0] val);
        for (int i = occupancy; i >= p; i--)
            cells[i] = cells[i-1];
        cells[p-1] = val;
        occupancy++;
    endfunction

    function void shift_out(int unsigned p);
        for (int i = p; i < occupancy; i++)
            cells[i-1] = cells[i];
        occupancy--;
    endfunction

    // predicts the results of one accepted item and updates the list copy
    function void note_item(logic [3:0] op, logic [7:0] pos, logic [31:0] val);
        logic [1:0]  st;
        int unsigned run_len;
        int unsigned idx;
        st = ST_OK;
        items++;
        case (op)
            OP_INS_HEAD, OP_INS_TAIL: begin
                if (occupancy >= DEPTH)
                    st = ST_FULL;
                else
                    shift_in((op == OP_INS_HEAD) ? 1 : occupancy + 1, val);
            end
            OP_INS_AT: begin
                // position is checked before fullness
                if (pos < 1 || pos > occupancy + 1)
                    st = ST_RANGE;
                else if (occupancy >= DEPTH)
                    st = ST_FULL;
                else
                    shift_in(pos, val);
            end
            OP_DEL_HEAD, OP_DEL_TAIL: begin
                if (occupancy == 0)
                    st = ST_EMPTY;
                else
                    shift_out((op == OP_DEL_HEAD) ? 1 : occupancy);
            end
            OP_DEL_AT: begin
                if (occupancy == 0)
                    st = ST_EMPTY;
                else if (pos < 1 || pos > occupancy)
                    st = ST_RANGE;
                else
                    shift_out(pos);
            end
            OP_REPLACE: begin
                if (pos < 1 || pos > occupancy)
                    st = ST_RANGE;
                else
                    cells[pos-1] = val;
            end
            OP_DUMP_FWD, OP_DUMP_REV: begin
                dumps++;
                if (occupancy == 0) begin
                    st = ST_EMPTY;
                end else begin
                    run_len = (occupancy < MAX_RUN) ? occupancy : MAX_RUN;
                    for (int unsigned k = 0; k < run_len; k++) begin
                        idx = (op == OP_DUMP_FWD) ? k : occupancy - 1 - k;
                        push_result(ST_OK, cells[idx], k + 1 == run_len);
                    end
                    return;
                end
            end
            default: st = ST_RANGE;
        endcase
        push_result(st, '0, 1'b1);
    endfunction

    task report_mismatch(string what);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch @%0t: %s", $time, what);
    endtask

    task check_result(logic [1:0] st, logic [31:0] val, logic [4:0] cnt, logic is_last);
        list_result_t e;
        results++;
        if (awaited_q.size() == 0) begin
            report_mismatch($sformatf("result with nothing awaited (status %0d value %h)",
                                      st, val));
            return;
        end
        e = awaited_q.pop_front();
        if (st !== e.status)
            report_mismatch($sformatf("status %0d, predicted %0d", st, e.status));
        if (val !== e.value)
            report_mismatch($sformatf("entry_value %h, predicted %h", val, e.value));
        if (cnt !== e.count)
            report_mismatch($sformatf("entry_count %0d, predicted %0d", cnt, e.count));
        if (is_last !== e.is_last)
            report_mismatch($sformatf("last %b, predicted %b", is_last, e.is_last));
    endtask
endclass

module tb_positional_list_engine;
    localparam int CLK_HALF      = 6;              // 12 ns period
    localparam int RESET_CYCLES  = 5;
    localparam int RANDOM_ITEMS  = 250;
    localparam int PHASES        = 4;
    localparam int MAX_GAP       = 8;
    localparam int DRAIN_LIMIT   = 4000;           // cycles allowed for results to come
    localparam int SETTLE_CYCLES = 20;
    localparam int TIMEOUT_NS    = 3_000_000;      // far above the slowest legal run
    localparam int DEPTH         = CAPACITY_DEF;

    // op codes the block does not know
    localparam logic [3:0] OP_BAD_FIRST = 4'd9;
    localparam logic [3:0] OP_BAD_LAST  = 4'd15;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic        [3:0]  cmd_op;
    logic        [7:0]  cmd_pos;
    logic signed [31:0] cmd_value;
    logic               o_valid;
    logic        [1:0]  o_status;
    logic signed [31:0] o_entry_value;
    logic        [4:0]  o_entry_count;
    logic               o_last;

    list_scoreboard sb = new();

    positional_list_engine #(
        .CAPACITY(DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (cmd_op),
        .i_position    (cmd_pos),
        .i_value       (cmd_value),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_entry_value (o_entry_value),
        .o_entry_count (o_entry_count),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // hard stop in case the block hangs on busy
    initial begin
        #TIMEOUT_NS;
        $display("tb: failure");
        $finish;
    end

    // Result side: the receiver can never stall, so every strobed cycle is a result.
    // Outputs are read at the edge that ends their cycle, before the block updates.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ($isunknown(o_valid))
                sb.report_mismatch("result strobe is unknown");
            else if (o_valid)
                sb.check_result(o_status, o_entry_value, o_entry_count, o_last);
        end
    end

    // Present one item and hold it until an edge sees start high with busy low.
    // Returns at the accepting edge, so the next item can follow back to back.
    task automatic drive_item(input logic [3:0] op, input logic [7:0] pos,
                              input logic [31:0] val);
        start     <= 1'b1;
        cmd_op    <= op;
        cmd_pos   <= pos;
        cmd_value <= val;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        sb.note_item(op, pos, val);
    endtask

    // Random sender gap; the fields carry junk meanwhile, which the block must ignore.
    task automatic idle_gap(input int pct);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < pct)
            gap++;
        if (gap > 0) begin
            start     <= 1'b0;
            cmd_op    <= 4'($urandom);
            cmd_pos   <= 8'($urandom);
            cmd_value <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sender holds off until every predicted result is in, then lets the block settle.
    task automatic wait_for_results();
        start <= 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && sb.pending() != 0; w++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int          idle_pct;
        int          roll;
        bit          filling;
        logic [3:0]  op;
        logic [7:0]  pos;
        logic [31:0] val;

        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        cmd_op    <= OP_INS_HEAD;
        cmd_pos   <= '0;
        cmd_value <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: empty list corners ----
        drive_item(OP_DUMP_FWD, 8'd0, '0);
        drive_item(OP_DUMP_REV, 8'd0, '0);
        drive_item(OP_DEL_HEAD, 8'd0, '0);
        drive_item(OP_DEL_TAIL, 8'd0, '0);
        drive_item(OP_DEL_AT,   8'd1, '0);           // empty wins over a valid slot
        drive_item(OP_REPLACE,  8'd1, 32'h1234_5678); // replace on empty is out of range
        drive_item(OP_INS_AT,   8'd0, 32'h0000_0001); // slot zero is never legal
        drive_item(OP_INS_AT,   8'd2, 32'h0000_0002); // past the end of an empty list
        // ---- build a short list with value extremes ----
        drive_item(OP_INS_AT,   8'd1, 32'h8000_0000);
        drive_item(OP_INS_HEAD, 8'd0, 32'h7fff_ffff);
        drive_item(OP_INS_TAIL, 8'd0, 32'hffff_ffff);
        drive_item(OP_INS_AT,   8'd4, 32'h0000_0000); // one past the tail is legal
        drive_item(OP_INS_AT,   8'd2, 32'h5a5a_5a5a);
        // ---- position checks on a populated list ----
        drive_item(OP_REPLACE,  8'd0,   32'hdead_beef);
        drive_item(OP_REPLACE,  8'd255, 32'hdead_beef);
        drive_item(OP_REPLACE,  8'd5,   32'ha5a5_a5a5);
        drive_item(OP_DEL_AT,   8'd0, '0);
        drive_item(OP_DEL_AT,   8'd6, '0);
        drive_item(OP_DEL_AT,   8'd3, '0);
        drive_item(OP_BAD_FIRST, 8'd1, '1);
        drive_item(OP_BAD_LAST,  8'd255, '1);
        drive_item(OP_DUMP_FWD, 8'd0, '0);
        drive_item(OP_DUMP_REV, 8'd0, '0);
        drive_item(OP_DEL_HEAD, 8'd0, '0);
        drive_item(OP_DEL_TAIL, 8'd0, '0);
        wait_for_results();

        // ---- random: phases of sender idling (none, half, about a fifth, none) ----
        // The op mix tides between filling and draining so the list keeps hitting
        // both full and empty; dumps then cover every length up to the full store.
        filling = 1'b1;
        for (int phase = 0; phase < PHASES; phase++) begin
            idle_pct = (phase == 1) ? 50 : (phase == 2) ? 21 : 0;
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                if (sb.occupancy >= DEPTH)
                    filling = 1'b0;
                else if (sb.occupancy == 0)
                    filling = 1'b1;

                roll = $urandom_range(99);
                if (roll < 4)
                    op = 4'($urandom_range(OP_BAD_LAST, OP_BAD_FIRST));
                else if (roll < 14)
                    op = $urandom_range(1) ? OP_DUMP_FWD : OP_DUMP_REV;
                else if (roll < 22)
                    op = OP_REPLACE;
                else if (($urandom_range(99) < 70) == filling)
                    op = 4'($urandom_range(OP_INS_AT, OP_INS_HEAD));
                else
                    op = 4'($urandom_range(OP_DEL_AT, OP_DEL_HEAD));

                // mostly around the live range, sometimes anywhere in the field
                if ($urandom_range(99) < 70)
                    pos = 8'($urandom_range(sb.occupancy + 1, 0));
                else
                    pos = 8'($urandom);

                case ($urandom_range(15))
                    0:       val = 32'h8000_0000;
                    1:       val = 32'h7fff_ffff;
                    2:       val = '0;
                    3:       val = '1;
                    default: val = $urandom;
                endcase

                idle_gap(idle_pct);
                drive_item(op, pos, val);
            end
            // every phase ends with the sender waiting for the full result stream
            wait_for_results();
        end

        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d predicted results never arrived",
                                         sb.pending()));

        $display("summary: %0d items, %0d results checked, %0d dumps, %0d mismatches",
                 sb.items, sb.results, sb.dumps, sb.errors);
        $display("summary: predicted status ok %0d, range %0d, full %0d, empty %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_RANGE],
                 sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY]);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
